// File: rtl/core/mis_pkg.sv
`default_nettype none

package mis_pkg;

    localparam int VALUE_W = 31;
    localparam int TDATA_W = 32;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic               ins;
        logic               drain;
        logic [VALUE_W-1:0] value;
    } ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/merge_insertion_sorter_top.sv
// Channel  Direction  Payload
// s_axis   in         tdata: value; tlast: last
// m_axis   out        tdata: value_res; tlast: last_res; tuser: dropped
//
// An input request is taken and inserted into the cell chain at once.
// After the request marked last, the chain shifts the batch out one result per
// accepted output cycle; no input is taken meanwhile.
// Reset empties every cell and clears the overflow flag; there is no clearing pass.
// A stalled output holds the chain and the result in place.
`default_nettype none

module merge_insertion_sorter_top
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [mis_pkg::TDATA_W-1:0] s_axis_tdata,  // [30:0] value, [31] zero
    input  wire logic                        s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [mis_pkg::TDATA_W-1:0]      m_axis_tdata,  // [30:0] value_res, [31] zero
    output logic                             m_axis_tlast,
    output logic [0:0]                       m_axis_tuser   // [0] dropped
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic            state_reg;
    logic            state_next;
    logic            overflow_reg;
    logic            overflow_next;
    logic            in_acc;
    logic            out_acc;
    logic            full;
    mis_pkg::ctrl_t  ctrl;
    mis_pkg::entry_t cell_q [CAPACITY];
    logic            cell_le [CAPACITY];
    mis_pkg::entry_t empty_entry;

    assign empty_entry = '{valid: 1'b0, value: '0};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_DRAIN);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign full          = cell_q[CAPACITY-1].valid;

    assign ctrl.ins   = in_acc && !full;
    assign ctrl.drain = out_acc;
    assign ctrl.value = s_axis_tdata[mis_pkg::VALUE_W-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            mis_pkg::entry_t prev_e;
            mis_pkg::entry_t next_e;
            logic            prev_le;
            if (gi == 0)
            begin : g_head
                assign prev_e  = empty_entry;
                assign prev_le = 1'b1;
            end
            else
            begin : g_body
                assign prev_e  = cell_q[gi-1];
                assign prev_le = cell_le[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_tail
                assign next_e = empty_entry;
            end
            else
            begin : g_inner
                assign next_e = cell_q[gi+1];
            end
            mis_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .prev_le (prev_le),
                .prev    (prev_e),
                .next    (next_e),
                .le      (cell_le[gi]),
                .q       (cell_q[gi])
            );
        end
    endgenerate

    assign m_axis_tdata    = {1'b0, cell_q[0].value};
    assign m_axis_tlast    = !cell_q[1].valid;
    assign m_axis_tuser[0] = overflow_reg;

    always_comb
    begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_acc && m_axis_tlast)
                begin
                    state_next    = ST_IDLE;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output sides active together");

    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (m_axis_tvalid && cell_q[0].valid))
        else $error("batch end did not start a nonempty drain");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (s_axis_tready && !cell_q[0].valid && !m_axis_tuser[0]))
        else $error("chain not empty after last result");
`endif

endmodule

`default_nettype wire

// File: rtl/core/mis_cell.sv
`default_nettype none

module mis_cell
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mis_pkg::ctrl_t  ctrl,
    input  wire logic            prev_le,
    input  wire mis_pkg::entry_t prev,
    input  wire mis_pkg::entry_t next,
    output logic                 le,
    output mis_pkg::entry_t      q
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [mis_pkg::VALUE_W-1:0] value_reg;
    logic [mis_pkg::VALUE_W-1:0] value_next;

    // The cell keeps its entry when it is not greater than the new value.
    assign le = valid_reg && (value_reg <= ctrl.value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.drain)
        begin
            valid_next = next.valid;
            value_next = next.value;
        end
        else if (ctrl.ins && !le)
        begin
            if (prev_le)
            begin
                valid_next = 1'b1;
                value_next = ctrl.value;
            end
            else
            begin
                valid_next = prev.valid;
                value_next = prev.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign q.valid = valid_reg;
    assign q.value = value_reg;

endmodule

`default_nettype wire

// File: tb/sv/sorted_batch_checker.sv
`default_nettype none

module sorted_batch_checker
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    input  wire logic                        s_axis_tready,
    input  wire logic [mis_pkg::TDATA_W-1:0] s_axis_tdata,
    input  wire logic                        s_axis_tlast,
    input  wire logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    input  wire logic [mis_pkg::TDATA_W-1:0] m_axis_tdata,
    input  wire logic                        m_axis_tlast,
    input  wire logic [0:0]                  m_axis_tuser,
    output int                               fail_count,
    output int                               results_pending
);

    localparam int VALUE_W = mis_pkg::VALUE_W;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               dropped;
    } sorted_result_t;

    logic [VALUE_W-1:0] batch_values[$];
    bit                 batch_overflow = 1'b0;
    sorted_result_t     results_due[$];
    int                 mismatches = 0;

    assign fail_count = mismatches;

    function automatic void insert_sorted(input logic [VALUE_W-1:0] v, input logic is_last);
        int             pos;
        sorted_result_t r;
        pos = 0;
        if (batch_values.size() >= CAPACITY)
        begin
            batch_overflow = 1'b1;
        end
        else
        begin
            while (pos < batch_values.size() && batch_values[pos] <= v)
                pos++;
            batch_values.insert(pos, v);
        end
        if (is_last)
        begin
            foreach (batch_values[k])
            begin
                r.value   = batch_values[k];
                r.last    = (k == batch_values.size() - 1);
                r.dropped = batch_overflow;
                results_due.insert(results_due.size(), r);
            end
            batch_values.delete();
            batch_overflow = 1'b0;
        end
    endfunction

    always @(posedge clk)
    begin
        sorted_result_t got;
        sorted_result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                insert_sorted(s_axis_tdata[VALUE_W-1:0], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.value   = m_axis_tdata[VALUE_W-1:0];
                got.last    = m_axis_tlast;
                got.dropped = m_axis_tuser[0];
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, %s %0d %s %0b %s %0b",
                             $time, "actual value", got.value, "last", got.last,
                             "dropped", got.dropped);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: result mismatch, expected value %0d last %0b dropped %0b,",
                                 $time, want.value, want.last, want.dropped);
                        $display("%0t: actual value %0d last %0b dropped %0b",
                                 $time, got.value, got.last, got.dropped);
                        mismatches++;
                    end
                end
            end
        end
        results_pending = results_due.size();
    end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none

module tb;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = mis_pkg::VALUE_W;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [mis_pkg::TDATA_W-1:0] s_axis_tdata  = '0;
    logic                        s_axis_tlast  = 1'b0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [mis_pkg::TDATA_W-1:0] m_axis_tdata;
    logic                        m_axis_tlast;
    logic [0:0]                  m_axis_tuser;

    int fail_count;
    int results_pending;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    merge_insertion_sorter_top #(.CAPACITY(CAPACITY)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    sorted_batch_checker #(.CAPACITY(CAPACITY)) checker_i
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .m_axis_tuser    (m_axis_tuser),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task automatic send_request(input logic [VALUE_W-1:0] v, input logic is_last);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, v};
        s_axis_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_batch(input int length);
        logic [VALUE_W-1:0] v;
        int                 pick;
        for (int i = 0; i < length; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                v = '0;
            else if (pick == 1)
                v = VALUE_MAX;
            else if (pick <= 4)
                v = VALUE_W'($urandom_range(0, 7));
            else
                v = VALUE_W'($urandom());
            send_request(v, i == length - 1);
        end
    endtask

    initial
    begin
        int phase_items;
        int batch_len;
        bit first_batch;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request('0, 1'b1);
        send_request(VALUE_MAX, 1'b1);
        send_request(VALUE_MAX, 1'b0);
        send_request('0, 1'b0);
        send_request(VALUE_W'(5), 1'b0);
        send_request(VALUE_W'(5), 1'b0);
        send_request(VALUE_MAX, 1'b0);
        send_request('0, 1'b0);
        send_request(VALUE_W'(1), 1'b1);
        send_request(VALUE_W'(31'h2AAA_AAAA), 1'b0);
        send_request(VALUE_W'(31'h5555_5555), 1'b0);
        send_request(VALUE_W'(31'h4000_0000), 1'b0);
        send_request(VALUE_W'(1), 1'b0);
        send_request(VALUE_MAX - 1'b1, 1'b0);
        send_request(VALUE_W'(3), 1'b0);
        send_request(VALUE_W'(3), 1'b1);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 66;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 66;
                end
                default:
                begin
                    sender_idle_pct    = 14;
                    receiver_stall_pct = 14;
                end
            endcase
            phase_items = 0;
            first_batch = 1'b1;
            while (phase_items < 95)
            begin
                if (first_batch && phase == 1)
                    batch_len = CAPACITY + 1;
                else if (first_batch && phase == 2)
                    batch_len = CAPACITY + 6;
                else if (first_batch && phase == 3)
                    batch_len = CAPACITY;
                else if ($urandom_range(0, 9) == 0)
                    batch_len = $urandom_range(CAPACITY - 4, CAPACITY + 4);
                else
                    batch_len = $urandom_range(1, 16);
                first_batch = 1'b0;
                send_batch(batch_len);
                phase_items += batch_len;
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("merge_insertion_sorter_top test passed");
        else
            $display("merge_insertion_sorter_top test failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("merge_insertion_sorter_top test failed");
        $finish;
    end

endmodule

`default_nettype wire
